@@ rtl/core/assert_macros.svh @@
// assertion macros used by the key/value table top level
// no dependencies; clk and rst_n must exist in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent relation checked at every clock edge outside reset
`define KVTL_CHECK(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication checked at every clock edge outside reset
`define KVTL_IMPLY(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

`endif

@@ rtl/core/kvtl_pkg.sv @@
// shared types and constants for the key/value table
// no dependencies
package kvtl_pkg;

    localparam int unsigned ENTRIES_DEF = 16;
    localparam int unsigned KEY_W       = 32;
    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned USED_W      = 5;
    localparam int unsigned IN_DATA_W   = 72;
    localparam int unsigned OUT_DATA_W  = 40;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // request as it travels down the row of cells
    typedef struct packed {
        logic               vld;
        req_type_t          req;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic               done;
        logic [VALUE_W-1:0] found;
    } stage_t;

endpackage

@@ rtl/core/kvtl_cell.sv @@
// one table entry plus the pipeline register that hands a request onward
// depends on kvtl_pkg
module kvtl_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  kvtl_pkg::stage_t stage_in,
    output kvtl_pkg::stage_t stage_out
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [kvtl_pkg::KEY_W-1:0]   key_reg;
    logic [kvtl_pkg::VALUE_W-1:0] value_reg;
    logic                         write_en;
    logic                         match;
    kvtl_pkg::stage_t             stage_reg;
    kvtl_pkg::stage_t             stage_next;

    assign match = valid_reg && (key_reg == stage_in.key);

    always_comb
    begin
        valid_next = valid_reg;
        write_en   = 1'b0;
        stage_next = stage_in;
        if (stage_in.vld)
        begin
            unique case (stage_in.req)
                kvtl_pkg::REQ_INSERT:
                begin
                    // first free entry takes the pair
                    if (!stage_in.done && !valid_reg)
                    begin
                        valid_next      = 1'b1;
                        write_en        = 1'b1;
                        stage_next.done = 1'b1;
                    end
                end
                kvtl_pkg::REQ_LOOKUP:
                begin
                    if (!stage_in.done && match)
                    begin
                        stage_next.done  = 1'b1;
                        stage_next.found = value_reg;
                    end
                end
                kvtl_pkg::REQ_DELETE:
                begin
                    if (!stage_in.done && match)
                    begin
                        valid_next      = 1'b0;
                        stage_next.done = 1'b1;
                    end
                end
                kvtl_pkg::REQ_CLEAR:
                begin
                    valid_next = 1'b0;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            stage_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && write_en)
        begin
            key_reg   <= stage_in.key;
            value_reg <= stage_in.value;
        end
    end

    assign stage_out = stage_reg;

endmodule

@@ rtl/core/key_value_table_linear.sv @@
// key/value table top level: row of entry cells, count and result register
// depends on kvtl_pkg, kvtl_cell and assert_macros.svh
`include "assert_macros.svh"

// Associative table of ENTRIES key/value pairs. Each request walks down a row of
// ENTRIES cells, one cell per cycle while the row moves, and each cell applies the
// request to its own entry, so a request sees every change made by the ones ahead
// of it. A result passes each cell's register in turn and then the result register;
// a new request can be taken every cycle, and the whole row holds only while a
// finished result waits at the output. Insert fills the lowest free entry (status
// full if none), lookup and delete act on the lowest valid matching entry, clear
// empties the table. Reset empties the table at once; no clearing pass is needed.
module key_value_table_linear
#(
    parameter int unsigned ENTRIES = kvtl_pkg::ENTRIES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // req_type[1:0], key[33:2], value[65:34], zero pad[71:66]
    input  logic [kvtl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status[1:0], hit[2], found_value[34:3], entries_used[39:35]
    output logic [kvtl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

    logic                         advance;
    kvtl_pkg::stage_t             head;
    kvtl_pkg::stage_t             chain [ENTRIES+1];
    kvtl_pkg::stage_t             last;
    logic [CNT_W-1:0]             cnt_reg;
    logic [CNT_W-1:0]             cnt_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    kvtl_pkg::status_t            status_reg;
    kvtl_pkg::status_t            status_next;
    logic                         hit_reg;
    logic                         hit_next;
    logic [kvtl_pkg::VALUE_W-1:0] found_reg;
    logic [kvtl_pkg::VALUE_W-1:0] found_next;
    logic [kvtl_pkg::USED_W-1:0]  used_reg;

    // the whole row moves unless a result is stuck at the output
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    always_comb
    begin
        head       = '0;
        head.vld   = s_axis_tvalid;
        head.req   = kvtl_pkg::req_type_t'(s_axis_tdata[1:0]);
        head.key   = s_axis_tdata[2 +: kvtl_pkg::KEY_W];
        head.value = s_axis_tdata[2 + kvtl_pkg::KEY_W +: kvtl_pkg::VALUE_W];
    end

    assign chain[0] = head;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        kvtl_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    assign last = chain[ENTRIES];

    always_comb
    begin
        cnt_next    = cnt_reg;
        status_next = kvtl_pkg::ST_OK;
        hit_next    = 1'b0;
        found_next  = '0;
        unique case (last.req)
            kvtl_pkg::REQ_INSERT:
            begin
                if (last.done)
                    cnt_next = cnt_reg + 1'b1;
                else
                    status_next = kvtl_pkg::ST_FULL;
            end
            kvtl_pkg::REQ_LOOKUP:
            begin
                if (last.done)
                begin
                    hit_next   = 1'b1;
                    found_next = last.found;
                end
                else
                    status_next = kvtl_pkg::ST_MISS;
            end
            kvtl_pkg::REQ_DELETE:
            begin
                if (last.done)
                begin
                    hit_next = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                    status_next = kvtl_pkg::ST_MISS;
            end
            kvtl_pkg::REQ_CLEAR:
            begin
                cnt_next = '0;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    assign out_valid_next = last.vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= out_valid_next;
            if (last.vld)
                cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last.vld)
        begin
            status_reg <= status_next;
            hit_reg    <= hit_next;
            found_reg  <= found_next;
            used_reg   <= kvtl_pkg::USED_W'(cnt_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {used_reg, found_reg, hit_reg, status_reg};

    `KVTL_CHECK(a_cnt_range, cnt_reg <= CNT_W'(ENTRIES), "entry count above table size")
    `KVTL_IMPLY(a_full_cnt, out_valid_reg && status_reg == kvtl_pkg::ST_FULL,
        cnt_reg == CNT_W'(ENTRIES), "table full reported with free entries")
    `KVTL_IMPLY(a_hit_ok, out_valid_reg && hit_reg,
        status_reg == kvtl_pkg::ST_OK, "hit with non-ok status")
    `KVTL_IMPLY(a_found_hit, out_valid_reg && found_reg != '0,
        hit_reg, "found value without a hit")

endmodule
